[rtl/multi_timer_scheduler_assert.svh]
// Assertion macros for the timer scheduler.
// Used by the top level; expects clk and rst_n in scope.
`ifndef MULTI_TIMER_SCHEDULER_ASSERT_SVH
`define MULTI_TIMER_SCHEDULER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mts_pkg.sv]
// Shared types and codes for the timer scheduler.
// No dependencies; imported by every module of the block.
package mts_pkg;

  localparam int OP_W        = 2;
  localparam int SEQ_W       = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_ADD    = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_FIRED   = 3'd0,
    ST_IDLE    = 3'd1,
    ST_ADDED   = 3'd2,
    ST_FULL    = 3'd3,
    ST_REMOVED = 3'd4,
    ST_MISSING = 3'd5
  } status_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } q_status_t;

endpackage

[rtl/mts_front.sv]
// Front end of the timer scheduler: accepts input beats and classifies them.
// Depends on mts_pkg; feeds the command queue.
module mts_front import mts_pkg::*; #(
  parameter int ID_BITS       = 8,
  parameter int INTERVAL_BITS = 31,
  parameter int CMD_W         = OP_W + ID_BITS + INTERVAL_BITS + 1
) (
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_kind,
  input  logic [ID_BITS-1:0]       in_timer_id,
  input  logic [INTERVAL_BITS-1:0] in_interval_ms,
  input  logic                     in_one_shot,
  input  q_status_t                q_status,
  output logic                     push,
  output logic [CMD_W-1:0]         push_data
);

  op_t op;

  always_comb begin
    case (in_kind)
      KIND_TICK:   op = OP_TICK;
      KIND_ADD:    op = OP_ADD;
      KIND_REMOVE: op = OP_REMOVE;
      default:     op = OP_NOP;
    endcase
  end

  assign in_ready  = !q_status.full;
  assign push      = in_valid && !q_status.full;
  assign push_data = {op, in_timer_id, in_interval_ms, in_one_shot};

endmodule

[rtl/mts_queue.sv]
// Short command queue between the front end and the execution engine.
// Depends on mts_pkg for the status struct.
module mts_queue import mts_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output q_status_t        q_status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign q_status.full     = (count_r == CNT_W'(DEPTH));
  assign q_status.nonempty = (count_r != '0);
  assign do_push  = push && !q_status.full;
  assign do_pop   = pop && q_status.nonempty;
  assign pop_data = data_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      data_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/mts_engine.sv]
// Execution engine of the timer scheduler: slot table, scans and result register.
// Depends on mts_pkg; takes commands from the queue.
module mts_engine import mts_pkg::*; #(
  parameter int ENTRIES       = 16,
  parameter int ID_BITS       = 8,
  parameter int INTERVAL_BITS = 31
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cmd_valid,
  output logic                     cmd_pop,
  input  op_t                      cmd_op,
  input  logic [ID_BITS-1:0]       cmd_id,
  input  logic [INTERVAL_BITS-1:0] cmd_interval,
  input  logic                     cmd_once,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [2:0]               out_status,
  output logic [ID_BITS-1:0]       out_result_id,
  output logic                     out_last
);

  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int MEM_DEPTH = 2 ** IDX_W;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ENTRIES);

  typedef struct packed {
    logic                     once;
    logic [ID_BITS-1:0]       ident;
    logic [INTERVAL_BITS-1:0] period;
    logic [INTERVAL_BITS-1:0] remaining;
    logic [SEQ_W-1:0]         stamp;
  } slot_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DEC  = 4'b0010,
    S_SCAN = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  slot_t slot_mem_r [MEM_DEPTH];
  slot_t rd_word_r;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]         chk_idx_r, chk_idx_nxt;
  logic [ENTRIES-1:0]       valid_r, valid_nxt;
  logic [ENTRIES-1:0]       due_r, due_nxt;
  logic [SEQ_W-1:0]         seq_r, seq_nxt;
  logic [SEQ_W-1:0]         seq0_r, seq0_nxt;
  logic                     found_r, found_nxt;
  logic [IDX_W-1:0]         best_idx_r, best_idx_nxt;
  slot_t                    best_word_r, best_word_nxt;
  logic [SEQ_W-1:0]         best_age_r, best_age_nxt;
  op_t                      op_r, op_nxt;
  logic [ID_BITS-1:0]       id_r, id_nxt;
  logic [INTERVAL_BITS-1:0] iv_r, iv_nxt;
  logic                     once_r, once_nxt;
  logic                     out_valid_r, out_valid_nxt;
  status_t                  out_status_r, out_status_nxt;
  logic [ID_BITS-1:0]       out_id_r, out_id_nxt;
  logic                     out_last_r, out_last_nxt;

  logic                     mem_we;
  logic [IDX_W-1:0]         mem_waddr;
  slot_t                    mem_wdata;
  logic [ENTRIES-1:0]       free_vec, free_low, pick_mask;
  logic [IDX_W-1:0]         free_idx;
  logic [SEQ_W-1:0]         age;
  logic [INTERVAL_BITS-1:0] dec_rem;
  logic                     cand, better, more_due, out_load;

  assign free_vec  = ~valid_r;
  assign free_low  = free_vec & (~free_vec + ENTRIES'(1));
  assign pick_mask = ENTRIES'(1) << best_idx_r;
  assign more_due  = |(due_r & ~pick_mask);
  assign out_load  = !out_valid_r || out_ready;
  assign age       = seq0_r - rd_word_r.stamp;
  assign dec_rem   = (rd_word_r.remaining == '0) ? '0
                   : rd_word_r.remaining - INTERVAL_BITS'(1);

  always_comb begin
    free_idx = '0;
    for (int b = 0; b < IDX_W; b++) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (((i >> b) & 1) == 1) begin
          free_idx[b] = free_idx[b] | free_low[i];
        end
      end
    end
  end

  always_comb begin
    if (op_r == OP_TICK) begin
      cand   = due_r[chk_idx_r];
      better = !found_r || (age > best_age_r);
    end else begin
      cand   = valid_r[chk_idx_r] && (rd_word_r.ident == id_r);
      better = !found_r || (rd_word_r.remaining < best_word_r.remaining) ||
               ((rd_word_r.remaining == best_word_r.remaining) && (age > best_age_r));
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = cnt_r[IDX_W-1:0];
    valid_nxt      = valid_r;
    due_nxt        = due_r;
    seq_nxt        = seq_r;
    seq0_nxt       = seq0_r;
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_word_nxt  = best_word_r;
    best_age_nxt   = best_age_r;
    op_nxt         = op_r;
    id_nxt         = id_r;
    iv_nxt         = iv_r;
    once_nxt       = once_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_waddr      = chk_idx_r;
    mem_wdata      = rd_word_r;
    cmd_pop        = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop  = 1'b1;
          op_nxt   = cmd_op;
          id_nxt   = cmd_id;
          iv_nxt   = cmd_interval;
          once_nxt = cmd_once;
          seq0_nxt = seq_r;
          cnt_nxt  = '0;
          case (cmd_op)
            OP_TICK: begin
              state_nxt = S_DEC;
            end
            OP_REMOVE: begin
              found_nxt = 1'b0;
              state_nxt = S_SCAN;
            end
            OP_ADD: begin
              found_nxt    = ~&valid_r;
              best_idx_nxt = free_idx;
              state_nxt    = S_EMIT;
            end
            default: begin
              state_nxt = S_EMIT;
            end
          endcase
        end
      end

      S_DEC: begin
        if (cnt_r != CNT_LAST) begin
          cnt_nxt     = cnt_r + CNT_W'(1);
          chk_vld_nxt = 1'b1;
        end
        if (chk_vld_r) begin
          due_nxt[chk_idx_r] = valid_r[chk_idx_r] && (dec_rem == '0);
          if (valid_r[chk_idx_r]) begin
            mem_we              = 1'b1;
            mem_wdata.remaining = dec_rem;
          end
        end
        if (cnt_r == CNT_LAST) begin
          cnt_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        if (cnt_r != CNT_LAST) begin
          cnt_nxt     = cnt_r + CNT_W'(1);
          chk_vld_nxt = 1'b1;
        end
        if (chk_vld_r && cand && better) begin
          found_nxt     = 1'b1;
          best_idx_nxt  = chk_idx_r;
          best_word_nxt = rd_word_r;
          best_age_nxt  = age;
        end
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
          case (op_r)
            OP_TICK: begin
              if (found_r) begin
                out_status_nxt      = ST_FIRED;
                out_id_nxt          = best_word_r.ident;
                out_last_nxt        = !more_due;
                due_nxt[best_idx_r] = 1'b0;
                if (best_word_r.once) begin
                  valid_nxt[best_idx_r] = 1'b0;
                end else begin
                  mem_we              = 1'b1;
                  mem_waddr           = best_idx_r;
                  mem_wdata           = best_word_r;
                  mem_wdata.remaining = best_word_r.period;
                  mem_wdata.stamp     = seq_r;
                  seq_nxt             = seq_r + SEQ_W'(1);
                end
                if (more_due) begin
                  cnt_nxt   = '0;
                  found_nxt = 1'b0;
                  state_nxt = S_SCAN;
                end
              end else begin
                out_status_nxt = ST_IDLE;
                out_id_nxt     = '0;
              end
            end
            OP_ADD: begin
              out_id_nxt = id_r;
              if (found_r) begin
                out_status_nxt        = ST_ADDED;
                valid_nxt[best_idx_r] = 1'b1;
                mem_we                = 1'b1;
                mem_waddr             = best_idx_r;
                mem_wdata             = '{once: once_r, ident: id_r, period: iv_r,
                                          remaining: iv_r, stamp: seq_r};
                seq_nxt               = seq_r + SEQ_W'(1);
              end else begin
                out_status_nxt = ST_FULL;
              end
            end
            OP_REMOVE: begin
              out_id_nxt = id_r;
              if (found_r) begin
                out_status_nxt        = ST_REMOVED;
                valid_nxt[best_idx_r] = 1'b0;
              end else begin
                out_status_nxt = ST_MISSING;
              end
            end
            default: begin
              out_status_nxt = ST_IDLE;
              out_id_nxt     = '0;
            end
          endcase
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      chk_vld_r   <= 1'b0;
      valid_r     <= '0;
      due_r       <= '0;
      seq_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      chk_vld_r   <= chk_vld_nxt;
      valid_r     <= valid_nxt;
      due_r       <= due_nxt;
      seq_r       <= seq_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r    <= chk_idx_nxt;
    seq0_r       <= seq0_nxt;
    best_idx_r   <= best_idx_nxt;
    best_word_r  <= best_word_nxt;
    best_age_r   <= best_age_nxt;
    op_r         <= op_nxt;
    id_r         <= id_nxt;
    iv_r         <= iv_nxt;
    once_r       <= once_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem_r[mem_waddr] <= mem_wdata;
    end
    rd_word_r <= slot_mem_r[cnt_r[IDX_W-1:0]];
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_result_id = out_id_r;
  assign out_last      = out_last_r;

endmodule

[rtl/multi_timer_scheduler.sv]
// Timer scheduler top level: front end, command queue and execution engine.
// Add and unused kinds go straight to the result; remove scans the slot table once.
// A tick with n due timers runs a decrement pass and then max(n, 1) scans, each
// visiting one slot per cycle through the slot memory port.
// Beats are accepted while the queue has room; results leave through a register.
// Synchronous reset frees every slot and clears the arm counter.
module multi_timer_scheduler import mts_pkg::*; #(
  parameter int ENTRIES       = 16,
  parameter int ID_BITS       = 8,
  parameter int INTERVAL_BITS = 31
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_kind,
  input  logic [ID_BITS-1:0]       in_timer_id,
  input  logic [INTERVAL_BITS-1:0] in_interval_ms,
  input  logic                     in_one_shot,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [2:0]               out_status,
  output logic [ID_BITS-1:0]       out_result_id,
  output logic                     out_last
);

  localparam int CMD_W = OP_W + ID_BITS + INTERVAL_BITS + 1;

  q_status_t                q_status;
  logic                     q_push, q_pop;
  logic [CMD_W-1:0]         q_push_data, q_pop_data;
  op_t                      cmd_op;
  logic [ID_BITS-1:0]       cmd_id;
  logic [INTERVAL_BITS-1:0] cmd_interval;
  logic                     cmd_once;

  mts_front #(
    .ID_BITS       (ID_BITS),
    .INTERVAL_BITS (INTERVAL_BITS),
    .CMD_W         (CMD_W)
  ) u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_timer_id    (in_timer_id),
    .in_interval_ms (in_interval_ms),
    .in_one_shot    (in_one_shot),
    .q_status       (q_status),
    .push           (q_push),
    .push_data      (q_push_data)
  );

  mts_queue #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .q_status  (q_status)
  );

  assign cmd_op       = op_t'(q_pop_data[CMD_W-1 -: OP_W]);
  assign cmd_id       = q_pop_data[INTERVAL_BITS+1 +: ID_BITS];
  assign cmd_interval = q_pop_data[1 +: INTERVAL_BITS];
  assign cmd_once     = q_pop_data[0];

  mts_engine #(
    .ENTRIES       (ENTRIES),
    .ID_BITS       (ID_BITS),
    .INTERVAL_BITS (INTERVAL_BITS)
  ) u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (q_status.nonempty),
    .cmd_pop       (q_pop),
    .cmd_op        (cmd_op),
    .cmd_id        (cmd_id),
    .cmd_interval  (cmd_interval),
    .cmd_once      (cmd_once),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_result_id (out_result_id),
    .out_last      (out_last)
  );

`include "multi_timer_scheduler_assert.svh"

  `MTS_ASSERT_NOW(a_single_is_last, out_valid && (out_status != ST_FIRED), out_last,
                  "non-fire result without last")
  `MTS_ASSERT_NOW(a_idle_id_zero, out_valid && (out_status == ST_IDLE),
                  out_result_id == '0, "idle result with nonzero id")
  `MTS_ASSERT_NEXT(a_queue_holds, q_status.nonempty && !q_pop, q_status.nonempty,
                   "queued command lost without a pop")

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for multi_timer_scheduler: directed table, then random commands.
// Depends on mts_pkg for command kinds and status codes; needs only the RTL.
module tb_top;
  import mts_pkg::*;

  localparam int ENTRIES    = 16;
  localparam int ID_W       = 8;
  localparam int IV_W       = 31;
  localparam int NUM_RANDOM = 380;

  typedef struct packed {
    status_t         status;
    logic [ID_W-1:0] rid;
    logic            last;
  } result_t;

  typedef struct {
    op_t             kind;
    logic [ID_W-1:0] id;
    logic [IV_W-1:0] iv;
    logic            once;
    int              reps;
    bit              typed;
    status_t         status;
    logic [ID_W-1:0] rid;
  } cmd_row_t;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  logic [1:0]      in_kind;
  logic [ID_W-1:0] in_timer_id;
  logic [IV_W-1:0] in_interval_ms;
  logic            in_one_shot;
  logic            out_valid;
  logic            out_ready;
  logic [2:0]      out_status;
  logic [ID_W-1:0] out_result_id;
  logic            out_last;

  logic            tmr_valid [ENTRIES];
  logic            tmr_once  [ENTRIES];
  logic [ID_W-1:0] tmr_ident [ENTRIES];
  logic [IV_W-1:0] tmr_period[ENTRIES];
  logic [IV_W-1:0] tmr_left  [ENTRIES];
  logic [31:0]     tmr_stamp [ENTRIES];
  logic [31:0]     arm_count;

  result_t pending_reports[$];
  result_t want;
  int      errors;
  int      beats_in;
  int      idle_pct;
  bit      hold_done;

  cmd_row_t plan [24] = '{
    '{OP_TICK,   8'h00, 31'd0,          1'b0, 1,  1'b1, ST_IDLE,    8'h00},
    '{OP_REMOVE, 8'h00, 31'd0,          1'b0, 1,  1'b1, ST_MISSING, 8'h00},
    '{OP_NOP,    8'hFF, 31'h7FFF_FFFF,  1'b1, 1,  1'b1, ST_IDLE,    8'h00},
    '{OP_ADD,    8'hFF, 31'd0,          1'b1, 1,  1'b1, ST_ADDED,   8'hFF},
    '{OP_TICK,   8'h00, 31'd0,          1'b0, 1,  1'b0, ST_IDLE,    8'h00},
    '{OP_ADD,    8'h00, 31'h7FFF_FFFF,  1'b0, 1,  1'b1, ST_ADDED,   8'h00},
    '{OP_ADD,    8'hAA, 31'd1,          1'b0, 1,  1'b1, ST_ADDED,   8'hAA},
    '{OP_ADD,    8'h55, 31'd1,          1'b1, 1,  1'b1, ST_ADDED,   8'h55},
    '{OP_TICK,   8'h00, 31'd0,          1'b0, 1,  1'b0, ST_IDLE,    8'h00},
    '{OP_TICK,   8'h00, 31'd0,          1'b0, 1,  1'b0, ST_IDLE,    8'h00},
    '{OP_REMOVE, 8'hAA, 31'd0,          1'b0, 1,  1'b1, ST_REMOVED, 8'hAA},
    '{OP_REMOVE, 8'h00, 31'd0,          1'b0, 1,  1'b1, ST_REMOVED, 8'h00},
    '{OP_ADD,    8'h3C, 31'd3,          1'b1, 16, 1'b0, ST_IDLE,    8'h00},
    '{OP_ADD,    8'h11, 31'd7,          1'b0, 1,  1'b1, ST_FULL,    8'h11},
    '{OP_TICK,   8'h00, 31'd0,          1'b0, 3,  1'b0, ST_IDLE,    8'h00},
    '{OP_ADD,    8'h3C, 31'd9,          1'b0, 1,  1'b0, ST_IDLE,    8'h00},
    '{OP_ADD,    8'h3C, 31'd4,          1'b0, 1,  1'b0, ST_IDLE,    8'h00},
    '{OP_REMOVE, 8'h3C, 31'd0,          1'b0, 1,  1'b0, ST_IDLE,    8'h00},
    '{OP_ADD,    8'h3C, 31'd9,          1'b0, 1,  1'b0, ST_IDLE,    8'h00},
    '{OP_REMOVE, 8'h3C, 31'd0,          1'b0, 1,  1'b0, ST_IDLE,    8'h00},
    '{OP_REMOVE, 8'h3C, 31'd0,          1'b0, 1,  1'b0, ST_IDLE,    8'h00},
    '{OP_ADD,    8'h01, 31'd0,          1'b0, 1,  1'b0, ST_IDLE,    8'h00},
    '{OP_TICK,   8'h00, 31'd0,          1'b0, 2,  1'b0, ST_IDLE,    8'h00},
    '{OP_REMOVE, 8'h01, 31'd0,          1'b0, 1,  1'b0, ST_IDLE,    8'h00}
  };

  multi_timer_scheduler #(
    .ENTRIES      (ENTRIES),
    .ID_BITS      (ID_W),
    .INTERVAL_BITS(IV_W)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_timer_id   (in_timer_id),
    .in_interval_ms(in_interval_ms),
    .in_one_shot   (in_one_shot),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_result_id (out_result_id),
    .out_last      (out_last)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic void timer_table_step(input op_t kind, input logic [ID_W-1:0] id,
                                           input logic [IV_W-1:0] iv, input logic once,
                                           ref result_t res[$]);
    bit due [ENTRIES];
    int order[$];
    int pick;
    int s;
    res.delete();
    case (kind)
      OP_TICK: begin
        for (int i = 0; i < ENTRIES; i++) begin
          due[i] = 1'b0;
          if (tmr_valid[i]) begin
            if (tmr_left[i] != '0) tmr_left[i] = tmr_left[i] - 1'b1;
            due[i] = (tmr_left[i] == '0);
          end
        end
        forever begin
          pick = -1;
          for (int i = 0; i < ENTRIES; i++)
            if (due[i] && (pick < 0 ||
                arm_count - tmr_stamp[i] > arm_count - tmr_stamp[pick]))
              pick = i;
          if (pick < 0) break;
          due[pick] = 1'b0;
          order.push_back(pick);
        end
        if (order.size() == 0) begin
          res.push_back('{ST_IDLE, '0, 1'b1});
        end else begin
          foreach (order[k])
            res.push_back('{ST_FIRED, tmr_ident[order[k]], k == order.size() - 1});
          foreach (order[k]) begin
            s = order[k];
            if (tmr_once[s]) begin
              tmr_valid[s] = 1'b0;
            end else begin
              tmr_left[s]  = tmr_period[s];
              tmr_stamp[s] = arm_count;
              arm_count    = arm_count + 1;
            end
          end
        end
      end
      OP_ADD: begin
        pick = -1;
        for (int i = 0; i < ENTRIES; i++)
          if (!tmr_valid[i] && pick < 0) pick = i;
        if (pick < 0) begin
          res.push_back('{ST_FULL, id, 1'b1});
        end else begin
          tmr_valid[pick]  = 1'b1;
          tmr_once[pick]   = once;
          tmr_ident[pick]  = id;
          tmr_period[pick] = iv;
          tmr_left[pick]   = iv;
          tmr_stamp[pick]  = arm_count;
          arm_count        = arm_count + 1;
          res.push_back('{ST_ADDED, id, 1'b1});
        end
      end
      OP_REMOVE: begin
        pick = -1;
        for (int i = 0; i < ENTRIES; i++) begin
          if (tmr_valid[i] && tmr_ident[i] == id) begin
            if (pick < 0 || tmr_left[i] < tmr_left[pick] ||
                (tmr_left[i] == tmr_left[pick] &&
                 arm_count - tmr_stamp[i] > arm_count - tmr_stamp[pick]))
              pick = i;
          end
        end
        if (pick < 0) begin
          res.push_back('{ST_MISSING, id, 1'b1});
        end else begin
          tmr_valid[pick] = 1'b0;
          res.push_back('{ST_REMOVED, id, 1'b1});
        end
      end
      default: begin
        res.push_back('{ST_IDLE, '0, 1'b1});
      end
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_cmd(input op_t kind, input logic [ID_W-1:0] id,
                          input logic [IV_W-1:0] iv, input logic once,
                          input bit typed, input status_t status,
                          input logic [ID_W-1:0] rid);
    result_t res[$];
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_timer_id    <= id;
    in_interval_ms <= iv;
    in_one_shot    <= once;
    do @(posedge clk); while (!in_ready);
    beats_in++;
    timer_table_step(kind, id, iv, once, res);
    if (typed) begin
      pending_reports.push_back('{status, rid, 1'b1});
    end else begin
      foreach (res[k]) pending_reports.push_back(res[k]);
    end
    @(negedge clk);
  endtask

  task automatic send_random_cmd();
    op_t             kind;
    logic [ID_W-1:0] id;
    logic [IV_W-1:0] iv;
    int              r;
    r = $urandom_range(0, 99);
    if (r < 45) kind = OP_TICK;
    else if (r < 75) kind = OP_ADD;
    else if (r < 95) kind = OP_REMOVE;
    else kind = OP_NOP;
    id = ($urandom_range(0, 99) < 80) ? ID_W'($urandom_range(0, 7)) : ID_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 80) iv = IV_W'($urandom_range(0, 12));
    else if (r < 90) iv = IV_W'($urandom_range(13, 60));
    else if (r < 97) iv = IV_W'($urandom);
    else iv = '1;
    if (kind == OP_TICK && $urandom_range(0, 1) == 0) begin
      id = ID_W'($urandom);
      iv = IV_W'($urandom);
    end
    send_cmd(kind, id, iv, 1'(($urandom_range(0, 1))), 1'b0, ST_IDLE, '0);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected beat: status %0d result_id %0d last %0d",
               out_status, out_result_id, out_last);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          errors++;
        end
        if (out_result_id !== want.rid) begin
          $error("result_id: expected %0d, got %0d", want.rid, out_result_id);
          errors++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_last);
          errors++;
        end
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && beats_in >= 120) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (250) @(negedge clk);
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_kind        = OP_NOP;
    in_timer_id    = '0;
    in_interval_ms = '0;
    in_one_shot    = 1'b0;
    errors         = 0;
    beats_in       = 0;
    idle_pct       = 20;
    hold_done      = 1'b0;
    arm_count      = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      tmr_valid[i]  = 1'b0;
      tmr_once[i]   = 1'b0;
      tmr_ident[i]  = '0;
      tmr_period[i] = '0;
      tmr_left[i]   = '0;
      tmr_stamp[i]  = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[r])
      repeat (plan[r].reps)
        send_cmd(plan[r].kind, plan[r].id, plan[r].iv, plan[r].once,
                 plan[r].typed, plan[r].status, plan[r].rid);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 40 == 0) idle_pct = 20 * $urandom_range(0, 2);
      if (n >= NUM_RANDOM - 60) idle_pct = 0;
      if (n == 200) begin
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_reports.size() != 0) @(negedge clk);
      end
      send_random_cmd();
    end
    in_valid <= 1'b0;

    while (pending_reports.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/mts_pkg.sv
rtl/mts_front.sv
rtl/mts_queue.sv
rtl/mts_engine.sv
rtl/multi_timer_scheduler.sv
dv/tb_top.sv
